[sv/xeu_pkg.sv]
package xeu_pkg;

    // characters of interest
    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_QUOT  = 8'h22;
    localparam logic [7:0] CH_APOS  = 8'h27;
    localparam logic [7:0] CH_L     = 8'h6C;
    localparam logic [7:0] CH_T     = 8'h74;
    localparam logic [7:0] CH_A     = 8'h61;
    localparam logic [7:0] CH_M     = 8'h6D;
    localparam logic [7:0] CH_P     = 8'h70;
    localparam logic [7:0] CH_O     = 8'h6F;
    localparam logic [7:0] CH_S     = 8'h73;
    localparam logic [7:0] CH_G     = 8'h67;
    localparam logic [7:0] CH_Q     = 8'h71;
    localparam logic [7:0] CH_U     = 8'h75;

    // trie positions, named by the prefix held
    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_AMP  = 4'd1;
    localparam logic [3:0] ST_L    = 4'd2;
    localparam logic [3:0] ST_LT   = 4'd3;
    localparam logic [3:0] ST_A    = 4'd4;
    localparam logic [3:0] ST_AM   = 4'd5;
    localparam logic [3:0] ST_AMP2 = 4'd6;
    localparam logic [3:0] ST_AP   = 4'd7;
    localparam logic [3:0] ST_APO  = 4'd8;
    localparam logic [3:0] ST_APOS = 4'd9;
    localparam logic [3:0] ST_G    = 4'd10;
    localparam logic [3:0] ST_GT   = 4'd11;
    localparam logic [3:0] ST_Q    = 4'd12;
    localparam logic [3:0] ST_QU   = 4'd13;
    localparam logic [3:0] ST_QUO  = 4'd14;
    localparam logic [3:0] ST_QUOT = 4'd15;

    typedef struct packed {
        logic [7:0] char_in;
        logic       end_of_string;
    } in_beat_t;

    typedef struct packed {
        logic [7:0] char_out;
        logic       last_out;
    } out_beat_t;

    // work for the back end: replay a held prefix, then an optional tail byte
    typedef struct packed {
        logic [3:0] flush_st;
        logic       tail_vld;
        logic [7:0] tail_char;
        logic       last;
    } job_t;

    // number of bytes held in a trie position
    function automatic logic [2:0] held_len(input logic [3:0] st);
        logic [2:0] len;
        unique case (st)
            ST_IDLE:                          len = 3'd0;
            ST_AMP:                           len = 3'd1;
            ST_L, ST_A, ST_G, ST_Q:           len = 3'd2;
            ST_LT, ST_AM, ST_AP, ST_GT, ST_QU: len = 3'd3;
            ST_AMP2, ST_APO, ST_QUO:          len = 3'd4;
            ST_APOS, ST_QUOT:                 len = 3'd5;
            default:                          len = 3'd0;
        endcase
        return len;
    endfunction

    // held prefix text, first byte in the top slot
    function automatic logic [39:0] held_text(input logic [3:0] st);
        logic [39:0] txt;
        unique case (st)
            ST_AMP:  txt = {CH_AMP, 32'h0};
            ST_L:    txt = {CH_AMP, CH_L, 24'h0};
            ST_LT:   txt = {CH_AMP, CH_L, CH_T, 16'h0};
            ST_A:    txt = {CH_AMP, CH_A, 24'h0};
            ST_AM:   txt = {CH_AMP, CH_A, CH_M, 16'h0};
            ST_AMP2: txt = {CH_AMP, CH_A, CH_M, CH_P, 8'h0};
            ST_AP:   txt = {CH_AMP, CH_A, CH_P, 16'h0};
            ST_APO:  txt = {CH_AMP, CH_A, CH_P, CH_O, 8'h0};
            ST_APOS: txt = {CH_AMP, CH_A, CH_P, CH_O, CH_S};
            ST_G:    txt = {CH_AMP, CH_G, 24'h0};
            ST_GT:   txt = {CH_AMP, CH_G, CH_T, 16'h0};
            ST_Q:    txt = {CH_AMP, CH_Q, 24'h0};
            ST_QU:   txt = {CH_AMP, CH_Q, CH_U, 16'h0};
            ST_QUO:  txt = {CH_AMP, CH_Q, CH_U, CH_O, 8'h0};
            ST_QUOT: txt = {CH_AMP, CH_Q, CH_U, CH_O, CH_T};
            default: txt = 40'h0;
        endcase
        return txt;
    endfunction

    // one byte of a held prefix
    function automatic logic [7:0] held_char(input logic [3:0] st, input logic [2:0] idx);
        logic [39:0] txt;
        logic [7:0]  ch;
        txt = held_text(st);
        unique case (idx)
            3'd0:    ch = txt[39:32];
            3'd1:    ch = txt[31:24];
            3'd2:    ch = txt[23:16];
            3'd3:    ch = txt[15:8];
            3'd4:    ch = txt[7:0];
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    // character produced by a closing semicolon, zero if the prefix is not complete
    function automatic logic [7:0] done_char(input logic [3:0] st);
        logic [7:0] ch;
        unique case (st)
            ST_LT:   ch = CH_LT;
            ST_AMP2: ch = CH_AMP;
            ST_APOS: ch = CH_APOS;
            ST_GT:   ch = CH_GT;
            ST_QUOT: ch = CH_QUOT;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    // next trie position, idle when the byte breaks the match
    function automatic logic [3:0] advance(input logic [3:0] st, input logic [7:0] c);
        logic [3:0] nx;
        nx = ST_IDLE;
        unique case (st)
            ST_AMP:
            begin
                if (c == CH_L)      nx = ST_L;
                else if (c == CH_A) nx = ST_A;
                else if (c == CH_G) nx = ST_G;
                else if (c == CH_Q) nx = ST_Q;
            end
            ST_L:   if (c == CH_T) nx = ST_LT;
            ST_A:
            begin
                if (c == CH_M)      nx = ST_AM;
                else if (c == CH_P) nx = ST_AP;
            end
            ST_AM:  if (c == CH_P) nx = ST_AMP2;
            ST_AP:  if (c == CH_O) nx = ST_APO;
            ST_APO: if (c == CH_S) nx = ST_APOS;
            ST_G:   if (c == CH_T) nx = ST_GT;
            ST_Q:   if (c == CH_U) nx = ST_QU;
            ST_QU:  if (c == CH_O) nx = ST_QUO;
            ST_QUO: if (c == CH_T) nx = ST_QUOT;
            default: nx = ST_IDLE;
        endcase
        return nx;
    endfunction

endpackage

[sv/xeu_front.sv]
module xeu_front
    import xeu_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  in_beat_t in_data,
    output logic     job_valid,
    input  logic     job_ready,
    output job_t     job
);

    logic [3:0] state_reg;
    logic [3:0] state_next;
    logic       take;

    assign in_ready = job_ready;
    assign take     = in_valid && in_ready;

    // classify the byte against the held prefix
    always_comb
    begin
        logic [3:0] nx;
        logic       fresh;
        nx         = advance(state_reg, in_data.char_in);
        fresh      = 1'b1;
        state_next = state_reg;
        job.flush_st  = ST_IDLE;
        job.tail_vld  = 1'b0;
        job.tail_char = in_data.char_in;
        job.last      = in_data.end_of_string;

        if (state_reg != ST_IDLE)
        begin
            fresh = 1'b0;
            if (in_data.char_in == CH_SEMI && done_char(state_reg) != 8'h00)
            begin
                job.tail_vld  = 1'b1;
                job.tail_char = done_char(state_reg);
                state_next    = ST_IDLE;
            end
            else if (nx != ST_IDLE)
            begin
                state_next = nx;
            end
            else
            begin
                job.flush_st = state_reg;
                state_next   = ST_IDLE;
                fresh        = 1'b1;
            end
        end

        if (fresh)
        begin
            if (in_data.char_in == CH_AMP)
                state_next = ST_AMP;
            else
                job.tail_vld = 1'b1;
        end

        // end of string flushes whatever prefix is still held
        if (in_data.end_of_string && state_next != ST_IDLE)
        begin
            if (job.flush_st == ST_IDLE)
            begin
                job.flush_st = state_next;
            end
            else
            begin
                job.tail_vld  = 1'b1;
                job.tail_char = CH_AMP;
            end
            state_next = ST_IDLE;
        end
    end

    assign job_valid = in_valid && (job.flush_st != ST_IDLE || job.tail_vld);

    // trie position
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else if (take)
            state_reg <= state_next;
    end

    a_end_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (take && in_data.end_of_string) |=> (state_reg == ST_IDLE))
        else $error("prefix still held after end of string");

endmodule

[sv/xeu_queue.sv]
module xeu_queue
    import xeu_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic wr_valid,
    output logic wr_ready,
    input  job_t wr_job,
    output logic rd_valid,
    input  logic rd_ready,
    output job_t rd_job
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    job_t            slot_reg [DEPTH];
    logic [AW-1:0]   wr_ptr_reg;
    logic [AW-1:0]   rd_ptr_reg;
    logic [CW-1:0]   count_reg;
    logic            push;
    logic            pop;

    assign wr_ready = (count_reg != CW'(DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_job   = slot_reg[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= wr_job;
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("queue fill count beyond depth");

endmodule

[sv/xeu_back.sv]
module xeu_back
    import xeu_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      job_valid,
    output logic      job_ready,
    input  job_t      job,
    output logic      out_valid,
    input  logic      out_ready,
    output out_beat_t out_data
);

    logic [2:0] idx_reg;
    logic [2:0] len;
    logic       final_byte;
    logic       step;
    logic [7:0] cur_char;
    logic       out_valid_reg;
    out_beat_t  out_data_reg;

    // pick the byte at the current replay position
    assign len        = held_len(job.flush_st);
    assign cur_char   = (idx_reg < len) ? held_char(job.flush_st, idx_reg) : job.tail_char;
    assign final_byte = job.tail_vld ? (idx_reg == len)
                                     : ({1'b0, idx_reg} + 4'd1 == {1'b0, len});
    assign step       = job_valid && (!out_valid_reg || out_ready);
    assign job_ready  = step && final_byte;

    // replay position within the job
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            idx_reg <= '0;
        else if (step)
            idx_reg <= final_byte ? 3'd0 : idx_reg + 3'd1;
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (step)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            out_data_reg.char_out <= cur_char;
            out_data_reg.last_out <= job.last && final_byte;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    a_idx_in_job: assert property (@(posedge clk) disable iff (!rst_n)
        job_valid |-> (idx_reg <= len))
        else $error("replay position past end of job");

    a_idx_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !job_valid |-> (idx_reg == 3'd0))
        else $error("replay position not cleared between jobs");

endmodule

[sv/xml_entity_unescape_unit.sv]
// xml entity unescape unit
// in channel (in_valid/in_ready/in_data) takes one escaped byte per beat with an
// end-of-string flag; out channel (out_valid/out_ready/out_data) gives unescaped
// bytes, last_out set on the final byte of each string.
// the front end walks the entity trie and turns each byte into a job: a held
// prefix to replay plus an optional tail byte. a small queue (QUEUE_DEPTH jobs)
// parts it from the back end, which emits one byte per cycle into an output
// register while the receiver is ready.
// throughput: one input byte per cycle while each byte gives at most one output
// byte and out_ready stays high; a broken match yields up to 6 output bytes.
// a job goes into the queue, then its bytes into the output register.
// reset clears the trie position, the queue and the output valid; nothing held.
// when the receiver stalls the output register holds, the queue fills, and
// in_ready drops once the queue is full.
module xml_entity_unescape_unit
    import xeu_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_beat_t  in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output out_beat_t out_data
);

    logic job_in_valid;
    logic job_in_ready;
    job_t job_in;
    logic job_out_valid;
    logic job_out_ready;
    job_t job_out;

    xeu_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .job_valid (job_in_valid),
        .job_ready (job_in_ready),
        .job       (job_in)
    );

    xeu_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (job_in_valid),
        .wr_ready (job_in_ready),
        .wr_job   (job_in),
        .rd_valid (job_out_valid),
        .rd_ready (job_out_ready),
        .rd_job   (job_out)
    );

    xeu_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (job_out_valid),
        .job_ready (job_out_ready),
        .job       (job_out),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule
